>>> src/egcd_pkg.sv
// egcd_pkg: payload types, constants and microcode table for the gcd block
// used by euclid_gcd_64; depends on nothing else
`default_nettype none

package egcd_pkg;

  // magnitude limit, 10^18
  localparam logic [63:0] MAG_LIMIT = 64'd1000000000000000000;

  localparam int unsigned DIV_W  = 60;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned SHIFT_W = 6;

  // input transfer payload
  typedef struct packed {
    logic signed [63:0] value_a;
    logic signed [63:0] value_b;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic [DIV_W-1:0] divisor;
    logic             error;
  } out_t;

  // branch conditions tested by a control word
  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_START     = 4'd1,
    C_ERR       = 4'd2,
    C_A_ZERO    = 4'd3,
    C_B_ZERO    = 4'd4,
    C_BOTH_EVEN = 4'd5,
    C_A_EVEN    = 4'd6,
    C_B_EVEN    = 4'd7,
    C_A_EQ_B    = 4'd8,
    C_OUT_FREE  = 4'd9
  } cond_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP        = 3'd0,
    OP_LOAD       = 3'd1,
    OP_COPY_B     = 3'd2,
    OP_HALVE_BOTH = 3'd3,
    OP_HALVE_A    = 3'd4,
    OP_HALVE_B    = 3'd5,
    OP_SUB_HALVE  = 3'd6,
    OP_SCALE      = 3'd7
  } op_t;

  // microprogram addresses
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_CHK_E  = 4'd1;
  localparam step_t ST_CHK_A  = 4'd2;
  localparam step_t ST_CHK_B  = 4'd3;
  localparam step_t ST_EVEN2  = 4'd4;
  localparam step_t ST_EVEN_A = 4'd5;
  localparam step_t ST_EVEN_B = 4'd6;
  localparam step_t ST_CMP    = 4'd7;
  localparam step_t ST_SCALE  = 4'd8;
  localparam step_t ST_EMIT   = 4'd9;

  // one control word: op and next step for each branch outcome
  typedef struct packed {
    cond_t cond;
    op_t   op_true;
    step_t tgt_true;
    op_t   op_false;
    step_t tgt_false;
  } ctrl_t;

  // microcode rom, binary gcd with shift-subtract reduction
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t cw;
    case (step)
      ST_IDLE:   cw = '{C_START,     OP_LOAD,       ST_CHK_E,  OP_NOP,       ST_IDLE};
      ST_CHK_E:  cw = '{C_ERR,       OP_NOP,        ST_EMIT,   OP_NOP,       ST_CHK_A};
      ST_CHK_A:  cw = '{C_A_ZERO,    OP_COPY_B,     ST_EMIT,   OP_NOP,       ST_CHK_B};
      ST_CHK_B:  cw = '{C_B_ZERO,    OP_NOP,        ST_EMIT,   OP_NOP,       ST_EVEN2};
      ST_EVEN2:  cw = '{C_BOTH_EVEN, OP_HALVE_BOTH, ST_EVEN2,  OP_NOP,       ST_EVEN_A};
      ST_EVEN_A: cw = '{C_A_EVEN,    OP_HALVE_A,    ST_EVEN_A, OP_NOP,       ST_EVEN_B};
      ST_EVEN_B: cw = '{C_B_EVEN,    OP_HALVE_B,    ST_EVEN_B, OP_NOP,       ST_CMP};
      ST_CMP:    cw = '{C_A_EQ_B,    OP_NOP,        ST_SCALE,  OP_SUB_HALVE, ST_EVEN_A};
      ST_SCALE:  cw = '{C_ALWAYS,    OP_SCALE,      ST_EMIT,   OP_NOP,       ST_EMIT};
      ST_EMIT:   cw = '{C_OUT_FREE,  OP_NOP,        ST_IDLE,   OP_NOP,       ST_EMIT};
      default:   cw = '{C_ALWAYS,    OP_NOP,        ST_IDLE,   OP_NOP,       ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> src/euclid_gcd_64.sv
// euclid_gcd_64: greatest common divisor of two signed 64-bit operands
// depends on egcd_pkg (payload types, limit constant, microcode rom)
//
// usage:
//   in channel: in_valid/in_ready with in_data (value_a, value_b). one pair is
//   taken while the sequencer sits at its idle step.
//   out channel: out_valid/out_ready with out_data (divisor, error), one result
//   per operand pair, in order.
//   error is set, with divisor zero, when either magnitude is above 10^18 or
//   both operands are zero.
//   sequencing: a microcoded sequencer drives one shared 60-bit subtract/shift
//   datapath, one control word per cycle. the run time depends on the operands:
//   error and zero cases leave from the checks for the emit step. otherwise each
//   loop pass is a compare/subtract step plus an exit from each halving step,
//   and the halvings and subtractions shrink the two magnitudes (under 120 bits
//   in all) until they meet.
//   the next pair can be accepted in the cycle after the result is written to the
//   output register, even if that result has not yet been taken.
//   stall: a held result stays in the output register; the sequencer waits at
//   its emit step until the register frees.
//   reset: synchronous, active low; returns to the idle step and drops out_valid.
`default_nettype none

module euclid_gcd_64 (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire egcd_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output egcd_pkg::out_t     out_data
);

  // sequencer and datapath registers
  egcd_pkg::step_t                 step_r, step_nxt;
  logic [egcd_pkg::DIV_W-1:0]      a_r, a_nxt;
  logic [egcd_pkg::DIV_W-1:0]      b_r, b_nxt;
  logic [egcd_pkg::SHIFT_W-1:0]    k_r, k_nxt;
  logic                            err_r, err_nxt;
  logic                            out_valid_r, out_valid_nxt;
  egcd_pkg::out_t                  out_data_r, out_data_nxt;

  egcd_pkg::ctrl_t cw;
  egcd_pkg::op_t   op;
  logic            cond_hit;
  logic            out_free;

  // operand magnitudes and range check
  logic [63:0] mag_a, mag_b;
  logic        over;
  logic [egcd_pkg::DIV_W:0]   diff_ab;
  logic [egcd_pkg::DIV_W-1:0] diff_ba;

  assign mag_a = in_data.value_a[63] ? (~in_data.value_a + 64'd1) : in_data.value_a;
  assign mag_b = in_data.value_b[63] ? (~in_data.value_b + 64'd1) : in_data.value_b;
  assign over  = (mag_a > egcd_pkg::MAG_LIMIT) || (mag_b > egcd_pkg::MAG_LIMIT) ||
                 ((mag_a == 64'd0) && (mag_b == 64'd0));

  // differences for the subtract-and-halve step, borrow gives the order
  assign diff_ab = {1'b0, a_r} - {1'b0, b_r};
  assign diff_ba = b_r - a_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (step_r == egcd_pkg::ST_IDLE);

  // control word fetch and branch condition
  always_comb begin
    cw = egcd_pkg::ucode_rom(step_r);
    case (cw.cond)
      egcd_pkg::C_ALWAYS:    cond_hit = 1'b1;
      egcd_pkg::C_START:     cond_hit = in_valid;
      egcd_pkg::C_ERR:       cond_hit = err_r;
      egcd_pkg::C_A_ZERO:    cond_hit = (a_r == '0);
      egcd_pkg::C_B_ZERO:    cond_hit = (b_r == '0);
      egcd_pkg::C_BOTH_EVEN: cond_hit = !a_r[0] && !b_r[0];
      egcd_pkg::C_A_EVEN:    cond_hit = !a_r[0];
      egcd_pkg::C_B_EVEN:    cond_hit = !b_r[0];
      egcd_pkg::C_A_EQ_B:    cond_hit = (a_r == b_r);
      egcd_pkg::C_OUT_FREE:  cond_hit = out_free;
      default:               cond_hit = 1'b0;
    endcase
    op       = cond_hit ? cw.op_true : cw.op_false;
    step_nxt = cond_hit ? cw.tgt_true : cw.tgt_false;
  end

  // datapath operations
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    err_nxt = err_r;
    case (op)
      egcd_pkg::OP_NOP: begin
      end
      egcd_pkg::OP_LOAD: begin
        a_nxt   = over ? '0 : mag_a[egcd_pkg::DIV_W-1:0];
        b_nxt   = over ? '0 : mag_b[egcd_pkg::DIV_W-1:0];
        k_nxt   = '0;
        err_nxt = over;
      end
      egcd_pkg::OP_COPY_B: begin
        a_nxt = b_r;
      end
      egcd_pkg::OP_HALVE_BOTH: begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end
      egcd_pkg::OP_HALVE_A: begin
        a_nxt = a_r >> 1;
      end
      egcd_pkg::OP_HALVE_B: begin
        b_nxt = b_r >> 1;
      end
      egcd_pkg::OP_SUB_HALVE: begin
        // both odd here, so the difference is even
        if (!diff_ab[egcd_pkg::DIV_W]) begin
          a_nxt = diff_ab[egcd_pkg::DIV_W:1];
        end else begin
          b_nxt = diff_ba >> 1;
        end
      end
      egcd_pkg::OP_SCALE: begin
        a_nxt = a_r << k_r;
      end
      default: begin
      end
    endcase
  end

  // output register, loaded when the emit step finds it free
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((step_r == egcd_pkg::ST_EMIT) && out_free) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.divisor = a_r;
      out_data_nxt.error   = err_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= egcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an error result always carries a zero divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.divisor == '0)
    else $error("error result with nonzero divisor");

  // a good result is never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.error |-> out_data.divisor != '0)
    else $error("zero divisor without error");

  // a new result only appears out of the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step_r) == egcd_pkg::ST_EMIT)
    else $error("result raised outside emit step");

  // an accepted pair starts the program at the error check
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> step_r == egcd_pkg::ST_CHK_E)
    else $error("accepted pair did not start the program");

  // the step counter stays inside the program
  assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= egcd_pkg::ST_EMIT)
    else $error("step counter outside program");

endmodule

`default_nettype wire

>>> sim/euclid_gcd_checker.sv
// euclid_gcd_checker: watches both channels of euclid_gcd_64, predicts each gcd result
// and compares it field by field; depends on egcd_pkg for the payload types
`default_nettype none

module euclid_gcd_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  wire egcd_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  wire egcd_pkg::out_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // expected results, oldest first
  egcd_pkg::out_t pending_gcds[$];
  int             fail_tally = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // magnitude of a two's complement operand, taken as unsigned
  function automatic logic [63:0] operand_mag(input logic [63:0] v);
    if (v[63]) begin
      return ~v + 64'd1;
    end
    return v;
  endfunction

  // gcd of the two magnitudes by remainder steps; error for out of range or both zero
  function automatic egcd_pkg::out_t gcd_of_pair(input egcd_pkg::in_t pair);
    logic [63:0]    x;
    logic [63:0]    y;
    logic [63:0]    r;
    egcd_pkg::out_t res;
    x = operand_mag(pair.value_a);
    y = operand_mag(pair.value_b);
    res = '0;
    if (x > egcd_pkg::MAG_LIMIT || y > egcd_pkg::MAG_LIMIT ||
        (x == 64'd0 && y == 64'd0)) begin
      res.error = 1'b1;
      return res;
    end
    if (x < y) begin
      r = x;
      x = y;
      y = r;
    end
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res.divisor = x[egcd_pkg::DIV_W-1:0];
    return res;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    fail_tally++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // result transfer is checked before the input transfer of the same edge is queued
  always @(posedge clk) begin : watch
    egcd_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_gcds.size() == 0) begin
          report_mismatch($sformatf("result divisor=%0d error=%0b with nothing expected",
                                    out_data.divisor, out_data.error));
        end else begin
          want = pending_gcds.pop_front();
          if (out_data.divisor !== want.divisor) begin
            report_mismatch($sformatf("divisor got %0d want %0d",
                                      out_data.divisor, want.divisor));
          end
          if (out_data.error !== want.error) begin
            report_mismatch($sformatf("error got %0b want %0b (divisor want %0d)",
                                      out_data.error, want.error, want.divisor));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_gcds.push_back(gcd_of_pair(in_data));
      end
    end
    pending    <= pending_gcds.size();
    fail_count <= fail_tally;
  end

endmodule

`default_nettype wire

>>> sim/euclid_gcd_64_tb.sv
// euclid_gcd_64_tb: drives operand pairs into euclid_gcd_64 and stalls its result side;
// depends on egcd_pkg, euclid_gcd_64 and euclid_gcd_checker
`default_nettype none

module euclid_gcd_64_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PAIRS = 1030;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 250;

  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  egcd_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  egcd_pkg::out_t out_data;
  int             fail_count;
  int             pending;
  logic           no_idle   = 1'b0;
  int             cycles    = 0;

  euclid_gcd_64 uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  euclid_gcd_checker gcd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] signed_of(input logic [63:0] mag);
    if ($urandom_range(0, 1) == 1) begin
      return ~mag + 64'd1;
    end
    return mag;
  endfunction

  // operand pick: in-range values, shared factors, limit edges, full width, zero and small values
  function automatic logic [63:0] pick_operand(input int kind, input logic [63:0] factor);
    logic [63:0] m;
    case (kind)
      0: m = rand64() % (egcd_pkg::MAG_LIMIT + 64'd1);
      1: m = factor * {32'd0, $urandom_range(1, 32'h1FFF_FFFF)};
      2: m = egcd_pkg::MAG_LIMIT + 64'd8 - 64'($urandom_range(0, 16));
      3: return rand64();
      4: m = 64'd0;
      default: m = 64'($urandom_range(0, 1000));
    endcase
    return signed_of(m);
  endfunction

  // result side stalls
  always @(posedge clk) begin : ready_gen
    int stall_left;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else if (no_idle) begin
      out_ready  <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left--;
    end else begin
      out_ready  <= 1'b1;
      stall_left = gap_len();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("euclid_gcd_64_tb: FAIL");
      $finish;
    end
  end

  // one input transfer; called at a rising edge, returns at the accepting edge
  task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value_a: a, value_b: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    int          kind_a;
    int          kind_b;
    int          r;
    logic [63:0] factor;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, signs, limit edges, most negative, full width
    send_pair(64'd0, 64'd0);
    send_pair(64'd0, 64'd5);
    send_pair(-64'sd7, 64'd0);
    send_pair(64'd0, ~egcd_pkg::MAG_LIMIT + 64'd1);
    send_pair(64'd1, 64'd1);
    send_pair(64'd12, 64'd18);
    send_pair(-64'sd12, 64'd18);
    send_pair(64'd12, -64'sd18);
    send_pair(-64'sd12, -64'sd18);
    send_pair(egcd_pkg::MAG_LIMIT, egcd_pkg::MAG_LIMIT);
    send_pair(egcd_pkg::MAG_LIMIT, ~egcd_pkg::MAG_LIMIT + 64'd1);
    send_pair(egcd_pkg::MAG_LIMIT, 64'd1);
    send_pair(egcd_pkg::MAG_LIMIT + 64'd1, 64'd3);
    send_pair(64'd3, ~(egcd_pkg::MAG_LIMIT + 64'd1) + 64'd1);
    send_pair(MIN_NEG, 64'd1);
    send_pair(64'd1, MIN_NEG);
    send_pair(MIN_NEG, MIN_NEG);
    send_pair(MAX_POS, MAX_POS);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(64'h0800_0000_0000_0000, 64'h0400_0000_0000_0000);
    send_pair(64'd999999999999999989, egcd_pkg::MAG_LIMIT);
    send_pair(64'd832040, 64'd514229);

    // random pairs, with stretches where neither side idles
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 150 == 100) no_idle <= 1'b1;
      if (i % 150 == 140) no_idle <= 1'b0;
      factor = {34'd0, 30'($urandom)} << $urandom_range(0, 3);
      if (factor == 64'd0) factor = 64'd1;
      r = $urandom_range(0, 99);
      if (r < 40) kind_a = 0;
      else if (r < 65) kind_a = 1;
      else if (r < 75) kind_a = 2;
      else if (r < 85) kind_a = 3;
      else if (r < 90) kind_a = 4;
      else kind_a = 5;
      // b mostly shares the kind of a so that shared factors line up
      kind_b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : kind_a;
      send_pair(pick_operand(kind_a, factor), pick_operand(kind_b, factor));
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    // wait for every result, then let the block sit idle a while
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("euclid_gcd_64_tb: PASS");
    end else begin
      $display("euclid_gcd_64_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/egcd_pkg.sv
src/euclid_gcd_64.sv
sim/euclid_gcd_checker.sv
sim/euclid_gcd_64_tb.sv
